/* hw/rtl/hgcd_pkg.sv */
// Package for the haversine great-circle distance unit.
// Holds the datapath beat types, fixed-point constants and the CORDIC angle table function.
// Depends on nothing.
`timescale 1ns / 1ps

package hgcd_pkg;

    // CORDIC datapath beat: Q40 vector, Q64-turn angle and quadrant tag.
    typedef struct packed {
        logic signed [43:0] x;
        logic signed [43:0] y;
        logic signed [63:0] z;
        logic [1:0]         quad;
    } cordic_t;

    // Square root datapath beat: remaining radicand and partial root.
    typedef struct packed {
        logic [60:0] v;
        logic [60:0] r;
    } sqrt_t;

    localparam int SQRT_STEPS = 31;
    localparam logic signed [43:0] GAIN_Q40 = 44'sd667681663043;
    localparam logic [63:0] INV2PI_Q64 = 64'h28BE60DB9391054A;
    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
    localparam logic [63:0] EIGHTH_TURN = 64'h2000000000000000;
    localparam logic [63:0] QUARTER_TURN = 64'h4000000000000000;
    localparam logic [60:0] ONE_Q60 = 61'h1000000000000000;
    localparam logic [22:0] RADIUS_RESET = 23'd6378137;
    localparam logic [32:0] RADIUS_SCALE = 33'd1000;

    // Divide by the odd number 2k+1; evaluated only while elaborating the table.
    function automatic logic [63:0] div_odd(input logic [63:0] v, input int unsigned k);
        logic [63:0] q;
        case (k)
            0:  q = v / 1;
            1:  q = v / 3;
            2:  q = v / 5;
            3:  q = v / 7;
            4:  q = v / 9;
            5:  q = v / 11;
            6:  q = v / 13;
            7:  q = v / 15;
            8:  q = v / 17;
            9:  q = v / 19;
            10: q = v / 21;
            11: q = v / 23;
            12: q = v / 25;
            13: q = v / 27;
            14: q = v / 29;
            15: q = v / 31;
            16: q = v / 33;
            17: q = v / 35;
            18: q = v / 37;
            19: q = v / 39;
            20: q = v / 41;
            21: q = v / 43;
            22: q = v / 45;
            23: q = v / 47;
            24: q = v / 49;
            25: q = v / 51;
            26: q = v / 53;
            27: q = v / 55;
            28: q = v / 57;
            29: q = v / 59;
            30: q = v / 61;
            31: q = v / 63;
            default: q = '0;
        endcase
        return q;
    endfunction

    // atan(2^-i) as a Q64 fraction of a turn, summed from its power series.
    function automatic logic [63:0] atan_turn(input int unsigned i);
        logic [63:0] sum;
        logic [63:0] term;
        int unsigned sh;
        int unsigned k;
        bit stop;
        sum = '0;
        stop = 1'b0;
        if (i == 0)
        begin
            return EIGHTH_TURN;
        end
        for (k = 0; k < 32; k++)
        begin
            if (!stop)
            begin
                sh = i * (2 * k + 1);
                if (sh >= 64)
                begin
                    stop = 1'b1;
                end
                else
                begin
                    term = div_odd(INV2PI_Q64 >> sh, k);
                    if (term == 0)
                    begin
                        stop = 1'b1;
                    end
                    else if (k[0])
                    begin
                        sum = sum - term;
                    end
                    else
                    begin
                        sum = sum + term;
                    end
                end
            end
        end
        return sum;
    endfunction

endpackage

/* hw/rtl/haversine_great_circle_distance_unit.sv */
// The path from the start beat to the done strobe runs through the two CORDIC cell rows
// and the 31-cell square root row.
// Throughput: one point pair per cycle; busy is always low and the pipeline never stalls.
// Reset clears the valid chain and sets the sphere radius to 6378137 m.
// Depends on hgcd_pkg, hgcd_cordic_cell and hgcd_sqrt_cell.
`timescale 1ns / 1ps

module haversine_great_circle_distance_unit #(
    parameter int CORDIC_STEPS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [22:0]        cfg_wr_data,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] lat_first,
    input  logic signed [31:0] lon_first,
    input  logic signed [31:0] lat_second,
    input  logic signed [31:0] lon_second,
    output logic               done,
    output logic [34:0]        distance_mm
);
    import hgcd_pkg::*;

    localparam int LATENCY = 2 * CORDIC_STEPS + 43;
    localparam logic signed [65:0] ROUND30 = 66'sd536870912;

    // Configuration register and the radius scaled to millimetres.
    logic [22:0] radius_reg;
    logic [32:0] radius_mm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= RADIUS_RESET;
            radius_mm_reg <= 33'(RADIUS_RESET) * RADIUS_SCALE;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                radius_reg <= cfg_wr_data;
            end
            radius_mm_reg <= 33'(radius_reg) * RADIUS_SCALE;
        end
    end

    // Valid chain alongside the datapath.
    logic [LATENCY-1:0] valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[LATENCY-2:0], start};
        end
    end

    assign busy = 1'b0;
    assign done = valid_reg[LATENCY-1];

    // Angle preparation: half differences and latitudes, folded to within an eighth turn of zero.
    function automatic cordic_t rot_start(input logic [63:0] ang);
        logic [63:0] u;
        cordic_t b;
        u = ang + EIGHTH_TURN;
        b.quad = u[63:62];
        b.z = $signed({2'b00, u[61:0]}) - $signed(EIGHTH_TURN);
        b.x = GAIN_Q40;
        b.y = '0;
        return b;
    endfunction

    logic [31:0] dlat;
    logic [31:0] dlon;
    cordic_t     rot_next [4];
    cordic_t     rot_reg  [4];

    always_comb
    begin
        dlat = lat_second - lat_first;
        dlon = lon_second - lon_first;
        rot_next[0] = rot_start({1'b0, dlat, 31'b0});
        rot_next[1] = rot_start({1'b0, dlon, 31'b0});
        rot_next[2] = rot_start({lat_first, 32'b0});
        rot_next[3] = rot_start({lat_second, 32'b0});
    end

    always_ff @(posedge clk)
    begin
        rot_reg <= rot_next;
    end

    // Four rotation CORDIC lanes: dlat/2, dlon/2, lat1, lat2.
    cordic_t rot_chain [4][CORDIC_STEPS+1];

    for (genvar ln = 0; ln < 4; ln++)
    begin : g_rot_lane
        assign rot_chain[ln][0] = rot_reg[ln];
        for (genvar st = 0; st < CORDIC_STEPS; st++)
        begin : g_rot_cell
            hgcd_cordic_cell #(
                .STEP      (st),
                .VECTORING (1'b0)
            ) u_cell (
                .clk      (clk),
                .beat_in  (rot_chain[ln][st]),
                .beat_out (rot_chain[ln][st+1])
            );
        end
    end

    // Rounding to Q30 and quadrant mapping.
    function automatic logic signed [32:0] rnd10(input logic signed [43:0] v);
        logic signed [43:0] t;
        t = (v + 44'sd512) >>> 10;
        return t[32:0];
    endfunction

    logic signed [32:0] cos_val [4];
    logic signed [32:0] sin_val [4];

    always_comb
    begin
        for (int ln = 0; ln < 4; ln++)
        begin
            case (rot_chain[ln][CORDIC_STEPS].quad)
                2'd0:
                begin
                    cos_val[ln] = rnd10(rot_chain[ln][CORDIC_STEPS].x);
                    sin_val[ln] = rnd10(rot_chain[ln][CORDIC_STEPS].y);
                end
                2'd1:
                begin
                    cos_val[ln] = -rnd10(rot_chain[ln][CORDIC_STEPS].y);
                    sin_val[ln] = rnd10(rot_chain[ln][CORDIC_STEPS].x);
                end
                2'd2:
                begin
                    cos_val[ln] = -rnd10(rot_chain[ln][CORDIC_STEPS].x);
                    sin_val[ln] = -rnd10(rot_chain[ln][CORDIC_STEPS].y);
                end
                default:
                begin
                    cos_val[ln] = rnd10(rot_chain[ln][CORDIC_STEPS].y);
                    sin_val[ln] = -rnd10(rot_chain[ln][CORDIC_STEPS].x);
                end
            endcase
        end
    end

    logic signed [32:0] sl0_reg;
    logic signed [32:0] sn0_reg;
    logic signed [32:0] c1_reg;
    logic signed [32:0] c2_reg;

    always_ff @(posedge clk)
    begin
        sl0_reg <= sin_val[0];
        sn0_reg <= sin_val[1];
        c1_reg  <= cos_val[2];
        c2_reg  <= cos_val[3];
    end

    // Products forming a = sin^2(dlat/2) + cos1 cos2 sin^2(dlon/2), over registered multiply and rounding stages.
    logic signed [65:0] cc_prod_reg;
    logic signed [65:0] ss1_reg;
    logic signed [32:0] sn1_reg;
    logic signed [32:0] cc30_reg;
    logic signed [65:0] ss2_reg;
    logic signed [32:0] sn2_reg;
    logic signed [65:0] m_prod_reg;
    logic signed [65:0] ss3_reg;
    logic signed [32:0] sn3_reg;
    logic signed [32:0] q30_reg;
    logic signed [65:0] ss4_reg;
    logic signed [32:0] sn4_reg;
    logic signed [65:0] qs_reg;
    logic signed [65:0] ss5_reg;
    logic signed [65:0] cc30_next;
    logic signed [65:0] q30_next;

    always_comb
    begin
        cc30_next = (cc_prod_reg + ROUND30) >>> 30;
        q30_next  = (m_prod_reg + ROUND30) >>> 30;
    end

    always_ff @(posedge clk)
    begin
        cc_prod_reg <= c1_reg * c2_reg;
        ss1_reg     <= sl0_reg * sl0_reg;
        sn1_reg     <= sn0_reg;
        cc30_reg    <= cc30_next[32:0];
        ss2_reg     <= ss1_reg;
        sn2_reg     <= sn1_reg;
        m_prod_reg  <= sn2_reg * cc30_reg;
        ss3_reg     <= ss2_reg;
        sn3_reg     <= sn2_reg;
        q30_reg     <= q30_next[32:0];
        ss4_reg     <= ss3_reg;
        sn4_reg     <= sn3_reg;
        qs_reg      <= q30_reg * sn4_reg;
        ss5_reg     <= ss4_reg;
    end

    // Clamp a to [0, 1] and seed both square root rows.
    logic signed [66:0] a_sum;
    logic [60:0]        ua;
    sqrt_t              sq_next [2];
    sqrt_t              sq_reg  [2];

    always_comb
    begin
        a_sum = 67'(ss5_reg) + 67'(qs_reg);
        if (a_sum < 0)
        begin
            ua = '0;
        end
        else if (a_sum > $signed({6'b0, ONE_Q60}))
        begin
            ua = ONE_Q60;
        end
        else
        begin
            ua = a_sum[60:0];
        end
        sq_next[0].v = ua;
        sq_next[0].r = '0;
        sq_next[1].v = ONE_Q60 - ua;
        sq_next[1].r = '0;
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

    // Square root rows: lane 0 gives sqrt(a), lane 1 gives sqrt(1-a).
    sqrt_t sq_chain [2][SQRT_STEPS+1];

    for (genvar ln = 0; ln < 2; ln++)
    begin : g_sqrt_lane
        assign sq_chain[ln][0] = sq_reg[ln];
        for (genvar st = 0; st < SQRT_STEPS; st++)
        begin : g_sqrt_cell
            hgcd_sqrt_cell #(
                .STEP (st)
            ) u_cell (
                .clk      (clk),
                .beat_in  (sq_chain[ln][st]),
                .beat_out (sq_chain[ln][st+1])
            );
        end
    end

    // Vectoring CORDIC row for atan2(sqrt a, sqrt(1-a)).
    cordic_t vec_chain [CORDIC_STEPS+1];

    always_comb
    begin
        vec_chain[0].x    = $signed({3'b000, sq_chain[1][SQRT_STEPS].r[30:0], 10'b0});
        vec_chain[0].y    = $signed({3'b000, sq_chain[0][SQRT_STEPS].r[30:0], 10'b0});
        vec_chain[0].z    = '0;
        vec_chain[0].quad = '0;
    end

    for (genvar st = 0; st < CORDIC_STEPS; st++)
    begin : g_vec_cell
        hgcd_cordic_cell #(
            .STEP      (st),
            .VECTORING (1'b1)
        ) u_cell (
            .clk      (clk),
            .beat_in  (vec_chain[st]),
            .beat_out (vec_chain[st+1])
        );
    end

    // Clamp the angle to a quarter turn and form the partial products with pi.
    logic [63:0] theta;
    logic [63:0] p00_reg;
    logic [63:0] p01_reg;
    logic [63:0] p10_reg;
    logic [63:0] p11_reg;

    always_comb
    begin
        if (vec_chain[CORDIC_STEPS].z < 0)
        begin
            theta = '0;
        end
        else if (vec_chain[CORDIC_STEPS].z > $signed(QUARTER_TURN))
        begin
            theta = QUARTER_TURN;
        end
        else
        begin
            theta = vec_chain[CORDIC_STEPS].z;
        end
    end

    always_ff @(posedge clk)
    begin
        p00_reg <= 64'(theta[31:0]) * 64'(PI_Q62[31:0]);
        p01_reg <= 64'(theta[31:0]) * 64'(PI_Q62[63:32]);
        p10_reg <= 64'(theta[63:32]) * 64'(PI_Q62[31:0]);
        p11_reg <= 64'(theta[63:32]) * 64'(PI_Q62[63:32]);
    end

    // Central angle in radians, Q3.29, rounded half up.
    logic [127:0] full_prod;
    logic [64:0]  h_sum;
    logic [31:0]  h_reg;

    always_comb
    begin
        full_prod = {p11_reg, 64'b0} + {32'b0, p01_reg, 32'b0}
                  + {32'b0, p10_reg, 32'b0} + {64'b0, p00_reg};
        h_sum = {1'b0, full_prod[127:64]} + 65'h40000000;
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_sum[62:31];
    end

    // Distance: radius in millimetres times h, split over two 16-bit halves of h.
    logic [48:0] plo_reg;
    logic [48:0] phi_reg;
    logic [64:0] dist_sum;
    logic [34:0] distance_reg;

    always_ff @(posedge clk)
    begin
        plo_reg <= 49'(radius_mm_reg) * 49'(h_reg[15:0]);
        phi_reg <= 49'(radius_mm_reg) * 49'(h_reg[31:16]);
    end

    always_comb
    begin
        dist_sum = {phi_reg, 16'b0} + 65'(plo_reg) + 65'h10000000;
    end

    always_ff @(posedge clk)
    begin
        distance_reg <= dist_sum[63:29];
    end

    assign distance_mm = distance_reg;

endmodule

/* hw/rtl/hgcd_cordic_cell.sv */
// One CORDIC iteration cell, rotation or vectoring mode, registered at its output.
// Depends on hgcd_pkg for the beat type and the angle table.
`timescale 1ns / 1ps

module hgcd_cordic_cell #(
    parameter int STEP      = 0,
    parameter bit VECTORING = 1'b0
) (
    input  logic              clk,
    input  hgcd_pkg::cordic_t beat_in,
    output hgcd_pkg::cordic_t beat_out
);
    import hgcd_pkg::*;

    localparam logic signed [63:0] ANGLE = $signed(atan_turn(STEP));

    logic               dir_pos;
    logic signed [43:0] dx;
    logic signed [43:0] dy;
    cordic_t            beat_next;
    cordic_t            beat_reg;

    // Rotation drives z toward zero; vectoring drives y toward zero.
    always_comb
    begin
        dx = beat_in.y >>> STEP;
        dy = beat_in.x >>> STEP;
        if (VECTORING)
        begin
            dir_pos = !(beat_in.y > 0);
        end
        else
        begin
            dir_pos = (beat_in.z >= 0);
        end
        beat_next.quad = beat_in.quad;
        if (dir_pos)
        begin
            beat_next.x = beat_in.x - dx;
            beat_next.y = beat_in.y + dy;
            beat_next.z = beat_in.z - ANGLE;
        end
        else
        begin
            beat_next.x = beat_in.x + dx;
            beat_next.y = beat_in.y - dy;
            beat_next.z = beat_in.z + ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign beat_out = beat_reg;

endmodule

/* hw/rtl/hgcd_sqrt_cell.sv */
// One digit cell of the restoring floor square root, registered at its output.
// Depends on hgcd_pkg for the beat type.
`timescale 1ns / 1ps

module hgcd_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic            clk,
    input  hgcd_pkg::sqrt_t beat_in,
    output hgcd_pkg::sqrt_t beat_out
);
    import hgcd_pkg::*;

    localparam int SH = 60 - 2 * STEP;
    localparam logic [60:0] BIT_VAL = 61'(1) << SH;

    logic [61:0] trial;
    sqrt_t       beat_next;
    sqrt_t       beat_reg;

    // Subtract the trial value when it fits and set this root digit.
    always_comb
    begin
        trial = {1'b0, beat_in.r} + {1'b0, BIT_VAL};
        if ({1'b0, beat_in.v} >= trial)
        begin
            beat_next.v = beat_in.v - trial[60:0];
            beat_next.r = (beat_in.r >> 1) + BIT_VAL;
        end
        else
        begin
            beat_next.v = beat_in.v;
            beat_next.r = beat_in.r >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign beat_out = beat_reg;

endmodule

/* hw/rtl/hgcd_checker.sv */
// Port-level checker for the haversine great-circle distance unit, with its bind.
// Depends on haversine_great_circle_distance_unit for the bind target.
`timescale 1ns / 1ps

module hgcd_checker #(
    parameter int LATENCY = 107
) (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [34:0] distance_mm
);

    // Half the circumference of the largest sphere, with a small margin for rounding.
    localparam logic [34:0] DIST_MAX = 35'd26353587000;

    // The pipeline never refuses a beat.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // Every result beat traces back to a start beat a fixed latency earlier.
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result beat without matching start");

    // A distance never exceeds half the circumference of the largest sphere.
    a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (distance_mm <= DIST_MAX))
        else $error("distance out of range");

    // A result beat lasts one cycle unless two start beats came back to back.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(done)) |-> $past(start, LATENCY + 1))
        else $error("result beat repeated");

endmodule

bind haversine_great_circle_distance_unit hgcd_checker #(
    .LATENCY (2 * CORDIC_STEPS + 43)
) u_hgcd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .distance_mm (distance_mm)
);
